// ----- rtl/btfc_pkg.sv -----
// Package for the block table free/coalesce engine.
// Holds field widths, status codes and the table entry type.
// No dependencies.
package btfc_pkg;

	localparam int ADDR_W           = 48;
	localparam int IN_IDX_W         = 6;
	localparam int OUT_CNT_W        = 7;
	localparam int DEF_TABLE_DEPTH  = 64;
	localparam int DEF_PAGE_BITS    = 12;

	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 264;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_BAD  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_FREE   = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] size;
		logic              busy;
	} entry_t;

endpackage

// ----- rtl/block_table_free_coalesce.sv -----
// Top level of the block table free/coalesce engine: sequencer, shared adder,
// result register. Depends on btfc_pkg and btfc_table.
//
// Channel  Dir  Handshake          Content
// s_*      in   tvalid/tready      tuser: kind; tdata: address, size, busy, index
// m_*      out  tvalid/tready      tdata: result word, fields listed at the port
// cfg_*    in   cfg_we             heap_base
//
// A free of a table of N entries makes one read per cycle for the neighbour
// scan, then one read per cycle for the compaction pass, both through the
// single table read port.
// Reset clears the counters and the heap end; the table is not cleared.
// A waiting result does not block acceptance, but a finished item waits for it.
module block_table_free_coalesce import btfc_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int PAGE_BITS   = DEF_PAGE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [47:0] entry_address, [95:48] entry_size, [96] entry_busy, [102:97] entry_index
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [0] kind
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [1:0] status, [49:2] clean_start, [97:50] clean_length, [145:98] merged_address,
	// [193:146] merged_size, [194] top_released, [242:195] heap_end_now,
	// [249:243] busy_count, [256:250] entry_count
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [ADDR_W-1:0]    cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CW    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;
	localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_BITS) - 64'd1);

	typedef enum logic [3:0] {
		S_IDLE, S_APPEND, S_FREE_RD, S_FREE_CHK, S_SCAN, S_MERGE1, S_MERGE2,
		S_CLEAN1, S_CLEAN2, S_CLEAN3, S_COMPACT, S_DONE
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] heap_end_q;
	logic [CNT_W-1:0]  len_q, busy_q;
	logic              ebusy_q;
	logic [ADDR_W-1:0] ea_q, es_q;
	logic [IN_IDX_W-1:0] idx_q;

	logic [ADDR_W-1:0] bstart_q, bsize_q, bend_q;
	logic              has_lo_q, has_hi_q;
	logic [CNT_W-1:0]  lo_q, hi_q, m_q;
	logic [ADDR_W-1:0] lo_addr_q, lo_size_q, hi_size_q;
	logic [ADDR_W-1:0] maddr_q, msize_q, end_q, up_q, clen_q;
	logic              top_q;
	logic [1:0]        status_q;
	logic [CNT_W-1:0]  rp_q, pos_s1, wp_q;
	logic              rm0_v_q, rm1_v_q, rm2_v_q;
	logic [CNT_W-1:0]  rm0_q, rm1_q;

	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// Table port
	logic             tb_we;
	logic [IDX_W-1:0] tb_waddr, tb_raddr;
	entry_t           tb_wdata, tb_rdata;

	btfc_table #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_table (
		.clk   (clk),
		.we    (tb_we),
		.waddr (tb_waddr),
		.wdata (tb_wdata),
		.raddr (tb_raddr),
		.rdata (tb_rdata)
	);

	// Shared adder, operands chosen by the sequencer state.
	logic [ADDR_W-1:0] add_a, add_b, add_sum;
	logic              add_c;

	always_comb begin
		add_a = '0;
		add_b = '0;
		add_c = 1'b0;
		case (state_q)
			S_APPEND: begin
				add_a = ea_q;
				add_b = es_q;
			end
			S_FREE_CHK, S_SCAN: begin
				add_a = tb_rdata.addr;
				add_b = tb_rdata.size;
			end
			S_MERGE1: begin
				add_a = has_lo_q ? lo_size_q : bsize_q;
				add_b = has_lo_q ? bsize_q : (has_hi_q ? hi_size_q : '0);
			end
			S_MERGE2: begin
				add_a = msize_q;
				add_b = (has_lo_q && has_hi_q) ? hi_size_q : '0;
			end
			S_CLEAN1: begin
				add_a = maddr_q;
				add_b = msize_q;
			end
			S_CLEAN2: begin
				add_a = maddr_q;
				add_b = PAGE_MASK;
			end
			S_CLEAN3: begin
				add_a = end_q;
				add_b = ~up_q;
				add_c = 1'b1;
			end
			default: begin
				add_a = '0;
			end
		endcase
		add_sum = add_a + add_b + ADDR_W'(add_c);
	end

	// Removal test for the entry arriving in the compaction pass.
	logic pos_removed;
	assign pos_removed = (rm0_v_q && pos_s1 == rm0_q) || (rm1_v_q && pos_s1 == rm1_q)
		|| (rm2_v_q && pos_s1 == m_q);

	always_comb begin
		tb_we    = 1'b0;
		tb_waddr = len_q[IDX_W-1:0];
		tb_wdata = '{addr: ea_q, size: es_q, busy: ebusy_q};
		tb_raddr = rp_q[IDX_W-1:0];
		case (state_q)
			S_APPEND: begin
				tb_we = (CNT_W'(TABLE_DEPTH) > len_q);
			end
			S_FREE_RD: begin
				tb_raddr = IDX_W'(idx_q);
			end
			S_FREE_CHK, S_CLEAN3: begin
				tb_raddr = '0;
			end
			S_COMPACT: begin
				tb_we    = !pos_removed;
				tb_waddr = wp_q[IDX_W-1:0];
				tb_wdata = (pos_s1 == m_q)
					? entry_t'{addr: maddr_q, size: msize_q, busy: 1'b0}
					: tb_rdata;
			end
			default: begin
				tb_we = 1'b0;
			end
		endcase
	end

	logic [ADDR_W-1:0] up_c;
	assign up_c = add_sum & ~PAGE_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			heap_end_q  <= '0;
			len_q       <= '0;
			busy_q      <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (len_q == '0) begin
					heap_end_q <= cfg_wdata;
				end
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ea_q     <= s_tdata[47:0];
						es_q     <= s_tdata[95:48];
						ebusy_q  <= s_tdata[96];
						idx_q    <= s_tdata[102:97];
						status_q <= STAT_OK;
						up_q     <= '0;
						clen_q   <= '0;
						maddr_q  <= '0;
						msize_q  <= '0;
						top_q    <= 1'b0;
						state_q  <= (s_tuser == KIND_FREE) ? S_FREE_RD : S_APPEND;
					end
				end
				S_APPEND: begin
					if (len_q >= CNT_W'(TABLE_DEPTH)) begin
						status_q <= STAT_FULL;
					end else begin
						len_q <= len_q + 1'b1;
						if (ebusy_q) begin
							busy_q <= busy_q + 1'b1;
						end
						if (add_sum > heap_end_q) begin
							heap_end_q <= add_sum;
						end
					end
					state_q <= S_DONE;
				end
				S_FREE_RD: begin
					if (CW'(idx_q) >= CW'(len_q)) begin
						status_q <= STAT_BAD;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FREE_CHK;
					end
				end
				S_FREE_CHK: begin
					if (!tb_rdata.busy) begin
						status_q <= STAT_BAD;
						state_q  <= S_DONE;
					end else begin
						bstart_q <= tb_rdata.addr;
						bsize_q  <= tb_rdata.size;
						bend_q   <= add_sum;
						has_lo_q <= 1'b0;
						has_hi_q <= 1'b0;
						pos_s1   <= '0;
						rp_q     <= CNT_W'(1);
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Later positions overwrite earlier hits, so the highest one wins.
					if (!tb_rdata.busy) begin
						if (add_sum == bstart_q) begin
							has_lo_q  <= 1'b1;
							lo_q      <= pos_s1;
							lo_addr_q <= tb_rdata.addr;
							lo_size_q <= tb_rdata.size;
						end else if (tb_rdata.addr == bend_q) begin
							has_hi_q  <= 1'b1;
							hi_q      <= pos_s1;
							hi_size_q <= tb_rdata.size;
						end
					end
					if (rp_q < len_q) begin
						pos_s1 <= rp_q;
						rp_q   <= rp_q + 1'b1;
					end else begin
						state_q <= S_MERGE1;
					end
				end
				S_MERGE1: begin
					msize_q <= add_sum;
					maddr_q <= has_lo_q ? lo_addr_q : bstart_q;
					m_q     <= has_lo_q ? lo_q : CNT_W'(idx_q);
					rm0_v_q <= has_lo_q;
					rm0_q   <= CNT_W'(idx_q);
					rm1_v_q <= has_hi_q;
					rm1_q   <= hi_q;
					state_q <= S_MERGE2;
				end
				S_MERGE2: begin
					msize_q <= add_sum;
					state_q <= S_CLEAN1;
				end
				S_CLEAN1: begin
					end_q   <= add_sum;
					state_q <= S_CLEAN2;
				end
				S_CLEAN2: begin
					up_q    <= up_c;
					// A rounded start that wrapped below the block start leaves nothing.
					clen_q  <= (add_sum >= maddr_q && up_c >= maddr_q) ? ADDR_W'(1) : '0;
					state_q <= S_CLEAN3;
				end
				S_CLEAN3: begin
					clen_q <= (clen_q[0] && end_q > up_q) ? (add_sum & ~PAGE_MASK) : '0;
					rm2_v_q <= (end_q == heap_end_q);
					if (end_q == heap_end_q) begin
						heap_end_q <= maddr_q;
						top_q      <= 1'b1;
					end
					if (busy_q != '0) begin
						busy_q <= busy_q - 1'b1;
					end
					pos_s1  <= '0;
					rp_q    <= CNT_W'(1);
					wp_q    <= '0;
					state_q <= S_COMPACT;
				end
				S_COMPACT: begin
					if (!pos_removed) begin
						wp_q <= wp_q + 1'b1;
					end
					if (rp_q < len_q) begin
						pos_s1 <= rp_q;
						rp_q   <= rp_q + 1'b1;
					end else begin
						len_q   <= pos_removed ? wp_q : wp_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {7'd0, OUT_CNT_W'(len_q), OUT_CNT_W'(busy_q), heap_end_q,
							top_q, msize_q, maddr_q, clen_q, up_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- rtl/btfc_table.sv -----
// Block table storage: one write port and one registered read port.
// Depends on btfc_pkg for the entry type.
module btfc_table import btfc_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int IDX_W       = $clog2(DEF_TABLE_DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem_q [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/btfc_checker.sv -----
// Port-level checks for the block table free/coalesce engine, bound to the top.
// Depends on btfc_pkg and block_table_free_coalesce.
module btfc_checker import btfc_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// A result word that is stalled stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	// Ready drops after an accepted word, since the sequencer leaves idle to process it.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after accepting a word");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[256:250] <= OUT_CNT_W'(TABLE_DEPTH)
			&& m_tdata[249:243] <= m_tdata[256:250])
		else $error("entry or busy count out of range");

	// A rejected item never releases the top block.
	a_err_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != STAT_OK |-> !m_tdata[194])
		else $error("top release reported on a rejected word");

endmodule

bind block_table_free_coalesce btfc_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_btfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/sv/block_table_free_coalesce_tb.sv -----
// Self-checking testbench for block_table_free_coalesce: append/free words in,
// one result word out per item, compared with a predictor of the block table.
// Depends on btfc_pkg and the block_table_free_coalesce RTL.
`timescale 1ns / 100ps

module block_table_free_coalesce_tb;
	import btfc_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;
	localparam logic [ADDR_W-1:0] PG_MASK = (48'd1 << DEF_PAGE_BITS) - 48'd1;

	typedef struct {
		logic              kind;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] size;
		logic              busy;
		logic [5:0]        idx;
	} op_t;

	typedef struct {
		logic [1:0]        status;
		logic [ADDR_W-1:0] clean_start;
		logic [ADDR_W-1:0] clean_length;
		logic [ADDR_W-1:0] merged_address;
		logic [ADDR_W-1:0] merged_size;
		logic              top_released;
		logic [ADDR_W-1:0] heap_end_now;
		logic [6:0]        busy_count;
		logic [6:0]        entry_count;
	} outcome_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [47:0] address, [95:48] size, [96] busy, [102:97] index
	logic                 s_tuser;   // [0] kind
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // status, clean_start, clean_length, merged_address,
	                                 // merged_size, top_released, heap_end_now, busy, entries
	logic                 cfg_we;
	logic [ADDR_W-1:0]    cfg_wdata;

	block_table_free_coalesce dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Shadow of the heap block table.
	logic [ADDR_W-1:0] tbl_addr [DEPTH];
	logic [ADDR_W-1:0] tbl_size [DEPTH];
	logic              tbl_busy [DEPTH];
	int                tbl_len;
	logic [ADDR_W-1:0] heap_end;
	int                busy_blocks;

	op_t      pending_ops [$];
	outcome_t expected_outcomes [$];
	int       fail_count;
	int       cyc;
	bit       word_taken;
	int       hold_left;
	bit       hold_done;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic erase_entry(input int pos);
		if (pos < tbl_len) begin
			for (int k = pos; k + 1 < tbl_len; k++) begin
				tbl_addr[k] = tbl_addr[k + 1];
				tbl_size[k] = tbl_size[k + 1];
				tbl_busy[k] = tbl_busy[k + 1];
			end
			tbl_len--;
		end
	endtask

	task automatic apply_heap_base(input logic [ADDR_W-1:0] v);
		if (tbl_len == 0) heap_end = v;
	endtask

	task automatic predict_outcome(input op_t op, output outcome_t r);
		logic [ADDR_W-1:0] bstart, bend, e, up, span_end;
		bit has_lo, has_hi;
		int lo, hi, m, other;
		r = '{default: '0};
		has_lo = 0;
		has_hi = 0;
		lo = 0;
		hi = 0;
		if (op.kind == KIND_APPEND) begin
			if (tbl_len >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				tbl_addr[tbl_len] = op.addr;
				tbl_size[tbl_len] = op.size;
				tbl_busy[tbl_len] = op.busy;
				if (op.busy) busy_blocks++;
				tbl_len++;
				e = op.addr + op.size;
				if (e > heap_end) heap_end = e;
			end
		end else if (int'(op.idx) >= tbl_len || !tbl_busy[op.idx]) begin
			r.status = STAT_BAD;
		end else begin
			bstart = tbl_addr[op.idx];
			bend = bstart + tbl_size[op.idx];
			for (int i = 0; i < tbl_len; i++) begin
				e = tbl_addr[i] + tbl_size[i];
				if (!tbl_busy[i]) begin
					if (e == bstart) begin
						has_lo = 1;
						lo = i;
					end else if (tbl_addr[i] == bend) begin
						has_hi = 1;
						hi = i;
					end
				end
			end
			if (has_lo) begin
				m = lo;
				tbl_size[lo] = tbl_size[lo] + tbl_size[op.idx];
				if (has_hi) tbl_size[lo] = tbl_size[lo] + tbl_size[hi];
				other = hi;
				erase_entry(op.idx);
				if (int'(op.idx) < m) m--;
				if (has_hi) begin
					if (other > int'(op.idx)) other--;
					erase_entry(other);
					if (other < m) m--;
				end
			end else begin
				m = op.idx;
				tbl_busy[op.idx] = 1'b0;
				if (has_hi) begin
					tbl_size[op.idx] = tbl_size[op.idx] + tbl_size[hi];
					erase_entry(hi);
					if (hi < m) m--;
				end
			end
			r.merged_address = tbl_addr[m];
			r.merged_size = tbl_size[m];
			span_end = r.merged_address + r.merged_size;
			up = (r.merged_address + PG_MASK) & ~PG_MASK;
			r.clean_start = up;
			if (up >= r.merged_address && span_end > up)
				r.clean_length = (span_end - up) & ~PG_MASK;
			if (span_end == heap_end) begin
				heap_end = r.merged_address;
				erase_entry(m);
				r.top_released = 1'b1;
			end
			if (busy_blocks > 0) busy_blocks--;
		end
		r.heap_end_now = heap_end;
		r.busy_count = 7'(busy_blocks);
		r.entry_count = 7'(tbl_len);
	endtask

	// Driver: offers queued words, with random gaps outside the quiet window.
	always @(negedge clk) begin
		cyc <= cyc + 1;
		if (!s_tvalid || word_taken) begin
			if (pending_ops.size() > 0 &&
			    ((cyc > 4000 && cyc < 12000) || $urandom_range(0, 99) >= 10)) begin
				op_t op;
				op = pending_ops.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= op.kind;
				s_tdata <= {1'b0, op.idx, op.busy, op.size, op.addr};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		word_taken = 1'b0;
	end

	// Receiver readiness, including one long hold-off to back the block up.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && cyc >= 2000) begin
			hold_done <= 1'b1;
			hold_left <= 1500;
			m_tready <= 1'b0;
		end else begin
			m_tready <= (cyc > 4000 && cyc < 12000) || $urandom_range(0, 99) >= 10;
		end
	end

	function automatic bit field_ok(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
			return 0;
		end
		return 1;
	endfunction

	// Input acceptance feeds the predictor; output acceptance is checked.
	always @(posedge clk) begin
		outcome_t r, w;
		bit ok;
		if (arst_n && s_tvalid && s_tready) begin
			op_t op;
			op.kind = s_tuser;
			op.addr = s_tdata[47:0];
			op.size = s_tdata[95:48];
			op.busy = s_tdata[96];
			op.idx = s_tdata[102:97];
			predict_outcome(op, r);
			expected_outcomes.push_back(r);
			word_taken = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_outcomes.size() == 0) begin
				$error("result word arrived with nothing expected");
				fail_count++;
			end else begin
				w = expected_outcomes.pop_front();
				ok = 1;
				ok &= field_ok("status", w.status, m_tdata[1:0]);
				ok &= field_ok("clean_start", w.clean_start, m_tdata[49:2]);
				ok &= field_ok("clean_length", w.clean_length, m_tdata[97:50]);
				ok &= field_ok("merged_address", w.merged_address, m_tdata[145:98]);
				ok &= field_ok("merged_size", w.merged_size, m_tdata[193:146]);
				ok &= field_ok("top_released", w.top_released, m_tdata[194]);
				ok &= field_ok("heap_end_now", w.heap_end_now, m_tdata[242:195]);
				ok &= field_ok("busy_count", w.busy_count, m_tdata[249:243]);
				ok &= field_ok("entry_count", w.entry_count, m_tdata[256:250]);
				if (!ok) fail_count++;
			end
		end
	end

	function automatic op_t mk_append(logic [47:0] a, logic [47:0] s, logic b);
		op_t op;
		op = '{kind: KIND_APPEND, addr: a, size: s, busy: b, idx: 6'($urandom)};
		return op;
	endfunction

	function automatic op_t mk_free(int i);
		op_t op;
		op = '{kind: KIND_FREE, addr: 48'({$urandom, $urandom}),
		       size: 48'({$urandom, $urandom}), busy: 1'($urandom), idx: 6'(i)};
		return op;
	endfunction

	task automatic wait_idle();
		while (pending_ops.size() > 0 || s_tvalid || expected_outcomes.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_heap_base(input logic [ADDR_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_heap_base(v);
	endtask

	initial begin
		int queued, est, n;
		logic [47:0] cursor, sz;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cyc = 0;
		fail_count = 0;
		hold_left = 0;
		hold_done = 0;
		word_taken = 0;
		tbl_len = 0;
		heap_end = '0;
		busy_blocks = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Heap base extremes while the table is empty; the last one sticks.
		write_heap_base(48'hFFFF_FFFF_FFFF);
		write_heap_base(48'h0);
		write_heap_base(48'h1000);

		// Directed: neighbours on both sides, bad frees, wrap, top release.
		pending_ops.push_back(mk_append(48'h1000, 48'h2000, 1));
		pending_ops.push_back(mk_append(48'h3000, 48'h800, 1));
		pending_ops.push_back(mk_append(48'h3800, 48'h1800, 0));
		pending_ops.push_back(mk_append(48'h0, 48'h1000, 0));
		pending_ops.push_back(mk_free(0));
		pending_ops.push_back(mk_free(40));
		pending_ops.push_back(mk_free(63));
		pending_ops.push_back(mk_free(2));
		pending_ops.push_back(mk_free(1));
		pending_ops.push_back(mk_append(48'hFFFF_FFFF_FFFF, 48'h2, 1));
		pending_ops.push_back(mk_append(48'h0, 48'h0, 0));
		pending_ops.push_back(mk_append(48'h1, 48'hFFFF_FFFF_FFFF, 1));
		pending_ops.push_back(mk_append(48'h10, 48'h20, 1));
		pending_ops.push_back(mk_free(0));
		pending_ops.push_back(mk_free(1));
		pending_ops.push_back(mk_free(0));
		pending_ops.push_back(mk_free(0));
		queued = 17;
		wait_idle();

		// Fill the table to the brim, then push on into the full state.
		write_heap_base(48'hFFFF_FFFF_F000);
		cursor = heap_end;
		for (int i = 0; i < DEPTH + 2; i++) begin
			sz = 48'($urandom_range(1, 4)) << 12;
			pending_ops.push_back(mk_append(cursor, sz, i % 3 != 0));
			cursor += sz;
		end
		queued += DEPTH + 2;
		wait_idle();
		write_heap_base(48'($urandom) << 16);

		// Random batches: mostly contiguous runs of blocks and frees inside them.
		while (queued < 450) begin
			wait_idle();
			if ($urandom_range(0, 3) == 0) write_heap_base(48'({$urandom, $urandom}));
			est = tbl_len;
			cursor = heap_end;
			n = $urandom_range(8, 16);
			for (int k = 0; k < n; k++) begin
				if (est < 56 && $urandom_range(0, 99) < 50) begin
					case ($urandom_range(0, 9))
						0: pending_ops.push_back(mk_append(48'({$urandom, $urandom}),
						                                   48'({$urandom, $urandom}),
						                                   1'($urandom)));
						1, 2: begin
							sz = 48'($urandom_range(1, 20000));
							pending_ops.push_back(mk_append(cursor, sz, 0));
							cursor += sz;
						end
						default: begin
							sz = (48'($urandom_range(1, 8)) << 12) +
							     ($urandom_range(0, 3) == 0 ? 48'($urandom_range(0, 4095)) : 0);
							pending_ops.push_back(mk_append(cursor, sz, 1));
							cursor += sz;
						end
					endcase
					est++;
				end else begin
					if ($urandom_range(0, 9) == 0 || est == 0)
						pending_ops.push_back(mk_free($urandom_range(0, 63)));
					else
						pending_ops.push_back(mk_free($urandom_range(0, est - 1)));
					if (est > 0) est--;
				end
				queued++;
			end
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASS block_table_free_coalesce");
		else
			$display("FAIL block_table_free_coalesce");
		$finish;
	end

	initial begin
		#16_000_000;
		$display("FAIL block_table_free_coalesce");
		$finish;
	end

endmodule
